>>> hdl/aisd_pkg.sv
// aisd_pkg: shared constants, codes and types for the array insert/search/delete block
// depends on nothing; imported by aisd_cell and array_insert_search_delete
`timescale 1ns / 1ps
`default_nettype none

package aisd_pkg;

	localparam int CAPACITY = 64;

	localparam int VALUE_W = 32;
	localparam int POS_W   = 7;
	localparam int KIND_W  = 2;
	localparam int STAT_W  = 2;
	localparam int FOUND_W = 6;
	localparam int ENTRY_W = 7;

	localparam int CNT_W = $clog2(CAPACITY + 1);
	localparam int AW    = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
	localparam int CMP_W = (CNT_W > POS_W) ? CNT_W : POS_W;

	localparam int IN_DATA_W  = ((POS_W + VALUE_W + 7) / 8) * 8;
	localparam int OUT_DATA_W = ((STAT_W + FOUND_W + ENTRY_W + 7) / 8) * 8;

	localparam logic [KIND_W-1:0] KIND_INSERT = 2'd0;
	localparam logic [KIND_W-1:0] KIND_SEARCH = 2'd1;
	localparam logic [KIND_W-1:0] KIND_DELETE = 2'd2;

	localparam logic [STAT_W-1:0] STAT_OK      = 2'd0;
	localparam logic [STAT_W-1:0] STAT_FULL    = 2'd1;
	localparam logic [STAT_W-1:0] STAT_BEYOND  = 2'd2;
	localparam logic [STAT_W-1:0] STAT_MISSING = 2'd3;

	typedef struct packed {
		logic load;
		logic from_prev;
		logic from_next;
	} aisd_cell_ctrl_t;

endpackage

`default_nettype wire

>>> hdl/aisd_cell.sv
// aisd_cell: one list slot, holds an entry, shifts to/from its neighbors and compares to the key
// depends on aisd_pkg
`timescale 1ns / 1ps
`default_nettype none

module aisd_cell
	import aisd_pkg::*;
(
	input  wire logic                  clk,
	input  wire aisd_cell_ctrl_t       ctrl,
	input  wire logic [VALUE_W-1:0]    ins_value,
	input  wire logic [VALUE_W-1:0]    prev_entry,
	input  wire logic [VALUE_W-1:0]    next_entry,
	input  wire logic [VALUE_W-1:0]    key,
	output logic      [VALUE_W-1:0]    entry,
	output logic                       hit
);

	logic [VALUE_W-1:0] entry_q;
	logic               hit_q;

	always_ff @(posedge clk) begin
		priority if (ctrl.load) begin
			entry_q <= ins_value;
		end else if (ctrl.from_prev) begin
			entry_q <= prev_entry;
		end else if (ctrl.from_next) begin
			entry_q <= next_entry;
		end else begin
			entry_q <= entry_q;
		end
		hit_q <= (entry_q == key);
	end

	assign entry = entry_q;
	assign hit   = hit_q;

endmodule

`default_nettype wire

>>> hdl/array_insert_search_delete.sv
// array_insert_search_delete: top level, command sequencer over a row of list cells
// depends on aisd_pkg and aisd_cell
//
// usage
//   s_* channel carries one command item: s_tuser is the kind (insert, search, delete),
//   s_tdata holds position_in and value_in. m_* channel returns one result item per
//   command: status, found_position and entry_count after the command.
// timing
//   an item is taken in the idle state; in the compare state every cell compares its entry
//   with the value; in the execute state, once the output register is free, the first hit
//   is encoded, the cells shift (insert, delete) and the result is loaded into the output
//   register. s_tready returns the cycle after, so no item is taken while one is in flight.
// reset
//   arst_n clears the count to zero (empty list) and the output valid flag; entries are
//   not cleared, since only positions below the count are ever read.
// back-pressure
//   a finished result waits in the output register while m_tready is low; the next
//   item is accepted meanwhile and waits at the shift step until the register is free.
`timescale 1ns / 1ps
`default_nettype none

module array_insert_search_delete
	import aisd_pkg::*;
(
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire logic                  s_tvalid,
	output logic                       s_tready,
	input  wire logic [IN_DATA_W-1:0]  s_tdata,   // position_in, value_in, zero pad
	input  wire logic [KIND_W-1:0]     s_tuser,   // kind
	output logic                       m_tvalid,
	input  wire logic                  m_tready,
	output logic      [OUT_DATA_W-1:0] m_tdata    // status, found_position, entry_count, zero pad
);

	localparam logic [1:0] ST_IDLE = 2'd0;
	localparam logic [1:0] ST_CMP  = 2'd1;
	localparam logic [1:0] ST_EXEC = 2'd2;

	logic [1:0]            state_q;
	logic [KIND_W-1:0]     kind_q;
	logic [POS_W-1:0]      pos_q;
	logic [VALUE_W-1:0]    key_q;
	logic [CNT_W-1:0]      count_q;
	logic                  m_valid_q;
	logic [STAT_W-1:0]     stat_q;
	logic [FOUND_W-1:0]    found_q;
	logic [ENTRY_W-1:0]    ecount_q;

	logic [VALUE_W-1:0]    entry_w [CAPACITY];
	logic [CAPACITY-1:0]   hit_w;
	logic [CAPACITY-1:0]   live;
	logic [CAPACITY-1:0]   first_hit;
	logic [AW-1:0]         hit_idx;
	logic                  any_hit;
	logic                  accept;
	logic                  exec_go;
	logic                  is_full;
	logic                  is_beyond;
	logic                  do_ins;
	logic                  do_del;
	logic [CMP_W-1:0]      pos_ext;
	logic [CMP_W-1:0]      cnt_ext;
	logic [STAT_W-1:0]     stat_n;
	logic [CNT_W-1:0]      count_n;

	assign accept   = s_tvalid && s_tready;
	assign s_tready = (state_q == ST_IDLE);
	assign exec_go  = (state_q == ST_EXEC) && (!m_valid_q || m_tready);

	assign pos_ext   = CMP_W'(pos_q);
	assign cnt_ext   = CMP_W'(count_q);
	assign is_full   = (count_q >= CNT_W'(CAPACITY));
	assign is_beyond = (pos_ext > cnt_ext);

	// first valid match: isolate the lowest set bit, then fold it to an index
	assign first_hit = live & (~live + CAPACITY'(1));
	assign any_hit   = |live;

	always_comb begin
		hit_idx = '0;
		for (int i = 0; i < CAPACITY; i++) begin
			if (first_hit[i]) begin
				hit_idx = hit_idx | AW'(i);
			end
		end
	end

	always_comb begin
		stat_n  = STAT_OK;
		count_n = count_q;
		do_ins  = 1'b0;
		do_del  = 1'b0;
		unique case (kind_q)
			KIND_INSERT: begin
				if (is_full) begin
					stat_n = STAT_FULL;
				end else if (is_beyond) begin
					stat_n = STAT_BEYOND;
				end else begin
					do_ins  = 1'b1;
					count_n = count_q + CNT_W'(1);
				end
			end
			KIND_SEARCH: begin
				if (!any_hit) begin
					stat_n = STAT_MISSING;
				end
			end
			KIND_DELETE: begin
				if (!any_hit) begin
					stat_n = STAT_MISSING;
				end else begin
					do_del  = 1'b1;
					count_n = count_q - CNT_W'(1);
				end
			end
			default: begin
				stat_n = STAT_OK;
			end
		endcase
	end

	genvar g;
	generate
		for (g = 0; g < CAPACITY; g++) begin : g_cell
			aisd_cell_ctrl_t    ctrl;
			logic [VALUE_W-1:0] prev_v;
			logic [VALUE_W-1:0] next_v;

			assign live[g] = hit_w[g] && (CNT_W'(g) < count_q);

			assign ctrl.load      = exec_go && do_ins && (CMP_W'(g) == pos_ext);
			assign ctrl.from_prev = exec_go && do_ins && (CMP_W'(g) > pos_ext);
			assign ctrl.from_next = exec_go && do_del && (AW'(g) >= hit_idx);

			if (g == 0) begin : g_first
				assign prev_v = entry_w[g];
			end else begin : g_mid_prev
				assign prev_v = entry_w[g-1];
			end
			if (g == CAPACITY - 1) begin : g_last
				assign next_v = entry_w[g];
			end else begin : g_mid_next
				assign next_v = entry_w[g+1];
			end

			aisd_cell u_cell (
				.clk        (clk),
				.ctrl       (ctrl),
				.ins_value  (key_q),
				.prev_entry (prev_v),
				.next_entry (next_v),
				.key        (key_q),
				.entry      (entry_w[g]),
				.hit        (hit_w[g])
			);
		end
	endgenerate

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= ST_IDLE;
			count_q   <= '0;
			m_valid_q <= 1'b0;
		end else begin
			if (exec_go) begin
				m_valid_q <= 1'b1;
			end else if (m_tready) begin
				m_valid_q <= 1'b0;
			end
			unique case (state_q)
				ST_IDLE: begin
					if (accept) begin
						state_q <= ST_CMP;
					end
				end
				ST_CMP: begin
					state_q <= ST_EXEC;
				end
				ST_EXEC: begin
					if (exec_go) begin
						state_q <= ST_IDLE;
						count_q <= count_n;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			kind_q <= s_tuser;
			pos_q  <= s_tdata[POS_W-1:0];
			key_q  <= s_tdata[POS_W+VALUE_W-1:POS_W];
		end
		if (exec_go) begin
			stat_q   <= stat_n;
			found_q  <= ((kind_q == KIND_SEARCH || kind_q == KIND_DELETE) && any_hit) ?
				FOUND_W'(hit_idx) : '0;
			ecount_q <= ENTRY_W'(count_n);
		end
	end

	assign m_tvalid = m_valid_q;
	assign m_tdata  = OUT_DATA_W'({ecount_q, found_q, stat_q});

endmodule

`default_nettype wire
